@@ hw/rtl/sfr_pkg.sv @@
// shared types, codes and the crc-8 step for the serial frame receiver
package sfr_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned SYNC_W      = 4;
   localparam int unsigned INDEX_W     = 10;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'hff;
   localparam logic [LEN_W-1:0]  MIN_FRAME_LEN  = 16'd6;
   localparam logic [SYNC_W-1:0] SYNC_MAX       = 4'd15;
   localparam logic [BYTE_W-1:0] CRC_POLY       = 8'h8c;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_BYTE    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LENGTH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNCS_NEEDED = 3'd4;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      V_PENDING = 3'd0,
      V_ACCEPT  = 3'd1,
      V_BADLEN  = 3'd2,
      V_NOEND   = 3'd3,
      V_CRC     = 3'd4,
      V_ADDR    = 3'd5
   } verdict_type;

   typedef struct packed {
      logic [BYTE_W-1:0] own_address;
      logic [BYTE_W-1:0] sync_byte;
      logic [BYTE_W-1:0] end_byte;
      logic [LEN_W-1:0]  min_length;
      logic [SYNC_W-1:0] syncs_needed;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic               in_frame;
      logic [INDEX_W-1:0] byte_index;
      logic               frame_end;
      verdict_type        verdict;
      logic [BYTE_W-1:0]  sender_address;
      logic               is_broadcast;
   } result_type;

   // reflected crc-8, polynomial 0x8c, one byte per call
   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/sfr_channels.sv @@
// request and response channel interfaces of the serial frame receiver

interface sfr_req_if;
   logic                         valid;
   logic                         ready;
   logic [sfr_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sfr_pkg::BYTE_W-1:0]   data_byte;
   logic                         in_frame;
   logic [sfr_pkg::INDEX_W-1:0]  byte_index;
   logic                         frame_end;
   logic [2:0]                   verdict;
   logic [sfr_pkg::BYTE_W-1:0]   sender_address;
   logic                         is_broadcast;

   modport source (output valid, output data_byte, output in_frame, output byte_index,
                   output frame_end, output verdict, output sender_address,
                   output is_broadcast, input ready);
   modport sink   (input valid, input data_byte, input in_frame, input byte_index,
                   input frame_end, input verdict, input sender_address,
                   input is_broadcast, output ready);
endinterface

@@ hw/rtl/sfr_parser.sv @@
// frame parser: sync hunt, header decode, crc check and verdict, one word per cycle while take is high
module sfr_parser #(
   parameter int unsigned MAX_FRAME_BYTES = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
   input  sfr_pkg::cfg_type            cfg,
   output sfr_pkg::result_type         result
);

   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES);
   localparam int unsigned CMP_W = sfr_pkg::LEN_W + 1;
   localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_FRAME_BYTES);

   sfr_pkg::phase_type                phase_ff, phase_in;
   logic [sfr_pkg::SYNC_W-1:0]        sync_seen_ff, sync_seen_in;
   logic [POS_W-1:0]                  position_ff, position_in;
   logic [sfr_pkg::LEN_W-1:0]         frame_length_ff, frame_length_in;
   logic [sfr_pkg::BYTE_W-1:0]        running_crc_ff, running_crc_in;
   logic                              crc_matched_ff, crc_matched_in;
   logic [sfr_pkg::BYTE_W-1:0]        dest_address_ff, dest_address_in;
   logic [sfr_pkg::BYTE_W-1:0]        src_address_ff, src_address_in;

   logic [sfr_pkg::SYNC_W-1:0]        need;
   logic [sfr_pkg::LEN_W-1:0]         new_length;
   logic [CMP_W-1:0]                  pos_plus2;
   logic [CMP_W-1:0]                  len_ext;
   logic                              len_bad;

   assign need = (cfg.syncs_needed == '0) ? sfr_pkg::SYNC_W'(1) : cfg.syncs_needed;
   assign new_length = {frame_length_ff[sfr_pkg::LEN_W-1:sfr_pkg::BYTE_W], rx_byte};
   assign pos_plus2 = CMP_W'(position_ff) + CMP_W'(2);
   assign len_ext = CMP_W'(frame_length_ff);
   assign len_bad = (new_length < cfg.min_length) || (new_length < sfr_pkg::MIN_FRAME_LEN)
                    || (CMP_W'(new_length) > MAX_LEN);

   // next state
   always_comb begin
      phase_in        = phase_ff;
      sync_seen_in    = sync_seen_ff;
      position_in     = position_ff;
      frame_length_in = frame_length_ff;
      running_crc_in  = running_crc_ff;
      crc_matched_in  = crc_matched_ff;
      dest_address_in = dest_address_ff;
      src_address_in  = src_address_ff;
      unique case (phase_ff)
         sfr_pkg::PH_HEADER: begin
            running_crc_in = sfr_pkg::crc8_step(running_crc_ff, rx_byte);
            unique case (position_ff[1:0])
               2'd0: begin
                  dest_address_in = rx_byte;
                  position_in     = POS_W'(1);
               end
               2'd1: begin
                  src_address_in = rx_byte;
                  position_in    = POS_W'(2);
               end
               2'd2: begin
                  frame_length_in = {rx_byte, {sfr_pkg::BYTE_W{1'b0}}};
                  position_in     = POS_W'(3);
               end
               default: begin
                  frame_length_in = new_length;
                  if (len_bad) begin
                     phase_in     = sfr_pkg::PH_HUNT;
                     sync_seen_in = '0;
                     position_in  = '0;
                  end else begin
                     phase_in    = sfr_pkg::PH_BODY;
                     position_in = POS_W'(4);
                  end
               end
            endcase
         end
         sfr_pkg::PH_BODY: begin
            if (pos_plus2 < len_ext) begin
               running_crc_in = sfr_pkg::crc8_step(running_crc_ff, rx_byte);
               position_in    = position_ff + POS_W'(1);
            end else if (pos_plus2 == len_ext) begin
               crc_matched_in = (running_crc_ff == rx_byte);
               position_in    = position_ff + POS_W'(1);
            end else begin
               phase_in     = sfr_pkg::PH_HUNT;
               sync_seen_in = '0;
               position_in  = '0;
            end
         end
         default: begin
            phase_in = sfr_pkg::PH_HUNT;
            if (rx_byte == cfg.sync_byte) begin
               sync_seen_in = (sync_seen_ff < sfr_pkg::SYNC_MAX) ?
                              sync_seen_ff + sfr_pkg::SYNC_W'(1) : sync_seen_ff;
               if (sync_seen_in >= need) begin
                  phase_in        = sfr_pkg::PH_HEADER;
                  position_in     = '0;
                  frame_length_in = '0;
                  running_crc_in  = '0;
                  crc_matched_in  = 1'b0;
               end
            end else begin
               sync_seen_in = '0;
            end
         end
      endcase
   end

   // result word
   always_comb begin
      result                = '0;
      result.data_byte      = rx_byte;
      result.verdict        = sfr_pkg::V_PENDING;
      unique case (phase_ff)
         sfr_pkg::PH_HEADER: begin
            result.in_frame   = 1'b1;
            result.byte_index = sfr_pkg::INDEX_W'(position_ff);
            if (position_ff[1:0] == 2'd3 && len_bad) begin
               result.frame_end = 1'b1;
               result.verdict   = sfr_pkg::V_BADLEN;
            end
         end
         sfr_pkg::PH_BODY: begin
            result.in_frame   = 1'b1;
            result.byte_index = sfr_pkg::INDEX_W'(position_ff);
            if (pos_plus2 > len_ext) begin
               result.frame_end = 1'b1;
               priority if (rx_byte != cfg.end_byte) begin
                  result.verdict = sfr_pkg::V_NOEND;
               end else if (!crc_matched_ff) begin
                  result.verdict = sfr_pkg::V_CRC;
               end else if (dest_address_ff != cfg.own_address &&
                            dest_address_ff != sfr_pkg::BROADCAST_ADDR) begin
                  result.verdict = sfr_pkg::V_ADDR;
               end else begin
                  result.verdict        = sfr_pkg::V_ACCEPT;
                  result.sender_address = src_address_ff;
                  result.is_broadcast   = (dest_address_ff == sfr_pkg::BROADCAST_ADDR);
               end
            end
         end
         default: begin
            result.in_frame = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sfr_pkg::PH_HUNT;
         sync_seen_ff <= '0;
         position_ff  <= '0;
      end else if (take) begin
         phase_ff     <= phase_in;
         sync_seen_ff <= sync_seen_in;
         position_ff  <= position_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         frame_length_ff <= frame_length_in;
         running_crc_ff  <= running_crc_in;
         crc_matched_ff  <= crc_matched_in;
         dest_address_ff <= dest_address_in;
         src_address_ff  <= src_address_in;
      end
   end

endmodule

@@ hw/rtl/serial_frame_receiver_crc8.sv @@
// top level of the serial frame receiver with crc-8 check
//
// req_ch carries one received byte per word; rsp_ch returns exactly one word
// for every byte taken: the byte itself, whether it sits in a frame, its index,
// and on the last byte of a frame (or on a rejected length) frame_end with a
// verdict, the sender address and the broadcast flag.
// csr_we/csr_index/csr_wdata write own_address, sync_byte, end_byte,
// min_length and syncs_needed; write them only while no word is in flight.
// A taken byte's result word is registered in the output register (in the skid
// register first while rsp_ch is stalled). Throughput is one byte per cycle while
// req_ch.ready is high; the parse state and crc-8 step update at acceptance.
// A second register behind the output lets req_ch keep going for one more word
// while rsp_ch is stalled; req_ch.ready drops only when both are full.
// Reset (synchronous, active high) empties both result registers, puts the
// parser back to hunting for sync and loads the register defaults
// (min_length 6, syncs_needed 2, the others 0).
module serial_frame_receiver_crc8 #(
   parameter int unsigned MAX_FRAME_BYTES = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   sfr_req_if.sink                           req_ch,
   sfr_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   sfr_pkg::cfg_type     cfg_ff;
   sfr_pkg::result_type  result;
   sfr_pkg::result_type  out_ff;
   sfr_pkg::result_type  skid_ff;
   logic                 out_valid_ff;
   logic                 skid_valid_ff;
   logic                 take;
   logic                 out_free;

   assign req_ch.ready = !skid_valid_ff;
   assign take         = req_ch.valid && req_ch.ready;
   assign out_free     = !out_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address  <= '0;
         cfg_ff.sync_byte    <= '0;
         cfg_ff.end_byte     <= '0;
         cfg_ff.min_length   <= 16'd6;
         cfg_ff.syncs_needed <= 4'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            sfr_pkg::CSR_OWN_ADDRESS:  cfg_ff.own_address  <= csr_wdata[7:0];
            sfr_pkg::CSR_SYNC_BYTE:    cfg_ff.sync_byte    <= csr_wdata[7:0];
            sfr_pkg::CSR_END_BYTE:     cfg_ff.end_byte     <= csr_wdata[7:0];
            sfr_pkg::CSR_MIN_LENGTH:   cfg_ff.min_length   <= csr_wdata;
            sfr_pkg::CSR_SYNCS_NEEDED: cfg_ff.syncs_needed <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   sfr_parser #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_ch.rx_byte),
      .cfg     (cfg_ff),
      .result  (result)
   );

   // output register with a skid stage behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            out_valid_ff <= skid_valid_ff || take;
         end
         if (skid_valid_ff) begin
            skid_valid_ff <= !rsp_ch.ready;
         end else begin
            skid_valid_ff <= take && !out_free;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end
      if (take && !out_free) begin
         skid_ff <= result;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.data_byte      = out_ff.data_byte;
   assign rsp_ch.in_frame       = out_ff.in_frame;
   assign rsp_ch.byte_index     = out_ff.byte_index;
   assign rsp_ch.frame_end      = out_ff.frame_end;
   assign rsp_ch.verdict        = out_ff.verdict;
   assign rsp_ch.sender_address = out_ff.sender_address;
   assign rsp_ch.is_broadcast   = out_ff.is_broadcast;

endmodule

@@ dv/tb.sv @@
// testbench for serial_frame_receiver_crc8: random framed byte streams checked word by word
`timescale 1ns / 1ps

module tb;

   localparam int MAX_FRAME_BYTES = 1024;
   localparam int CYCLE_LIMIT     = 600000;

   // tracks the receiver's parse state and holds the result words still owed
   class rx_frame_tracker;
      sfr_pkg::cfg_type     cfg;
      sfr_pkg::phase_type   phase;
      logic [3:0]           sync_seen;
      logic [9:0]           position;
      logic [15:0]          frame_len;
      logic [7:0]           crc;
      logic                 crc_ok;
      logic [7:0]           dest;
      logic [7:0]           src;
      sfr_pkg::result_type  expected_words[$];
      int                   errors;
      int                   words_seen;

      function new();
         cfg = '0;
         cfg.min_length = 16'd6;
         cfg.syncs_needed = 4'd2;
         phase = sfr_pkg::PH_HUNT;
         sync_seen = '0;
         position = '0;
         frame_len = '0;
         crc = '0;
         crc_ok = 1'b0;
         dest = '0;
         src = '0;
         errors = 0;
         words_seen = 0;
      endfunction

      // bitwise form of the reflected crc-8, data taken lsb first
      function logic [7:0] crc_next(logic [7:0] c, logic [7:0] d);
         logic fb;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c = c >> 1;
            if (fb) begin
               c = c ^ sfr_pkg::CRC_POLY;
            end
         end
         return c;
      endfunction

      function void set_reg(logic [sfr_pkg::CSR_INDEX_W-1:0] idx,
                            logic [sfr_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            sfr_pkg::CSR_OWN_ADDRESS:  cfg.own_address = val[7:0];
            sfr_pkg::CSR_SYNC_BYTE:    cfg.sync_byte = val[7:0];
            sfr_pkg::CSR_END_BYTE:     cfg.end_byte = val[7:0];
            sfr_pkg::CSR_MIN_LENGTH:   cfg.min_length = val;
            sfr_pkg::CSR_SYNCS_NEEDED: cfg.syncs_needed = val[3:0];
            default: ;
         endcase
      endfunction

      function void go_hunt();
         phase = sfr_pkg::PH_HUNT;
         sync_seen = '0;
         position = '0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void note_byte(logic [7:0] b);
         sfr_pkg::result_type r;
         int need;
         int idx;
         r = '0;
         r.data_byte = b;
         r.verdict = sfr_pkg::V_PENDING;
         need = (cfg.syncs_needed == 0) ? 1 : int'(cfg.syncs_needed);
         if (phase == sfr_pkg::PH_HEADER || phase == sfr_pkg::PH_BODY) begin
            idx = int'(position);
            r.in_frame = 1'b1;
            r.byte_index = position;
            if (phase == sfr_pkg::PH_HEADER) begin
               crc = crc_next(crc, b);
               case (idx)
                  0: dest = b;
                  1: src = b;
                  2: frame_len = {b, 8'h00};
                  default: begin
                     frame_len[7:0] = b;
                     if (frame_len < cfg.min_length || frame_len < sfr_pkg::MIN_FRAME_LEN ||
                         int'(frame_len) > MAX_FRAME_BYTES) begin
                        r.frame_end = 1'b1;
                        r.verdict = sfr_pkg::V_BADLEN;
                        go_hunt();
                     end else begin
                        phase = sfr_pkg::PH_BODY;
                     end
                  end
               endcase
               if (phase == sfr_pkg::PH_HEADER) begin
                  position = 10'((idx + 1) % 4);
               end else if (phase == sfr_pkg::PH_BODY) begin
                  position = 10'd4;
               end
            end else if (idx + 2 < int'(frame_len)) begin
               crc = crc_next(crc, b);
               position = position + 10'd1;
            end else if (idx + 2 == int'(frame_len)) begin
               crc_ok = (crc == b);
               position = position + 10'd1;
            end else begin
               // last byte: end byte first, then crc, then address
               r.frame_end = 1'b1;
               if (b != cfg.end_byte) begin
                  r.verdict = sfr_pkg::V_NOEND;
               end else if (!crc_ok) begin
                  r.verdict = sfr_pkg::V_CRC;
               end else if (dest != cfg.own_address && dest != sfr_pkg::BROADCAST_ADDR) begin
                  r.verdict = sfr_pkg::V_ADDR;
               end else begin
                  r.verdict = sfr_pkg::V_ACCEPT;
                  r.sender_address = src;
                  r.is_broadcast = (dest == sfr_pkg::BROADCAST_ADDR);
               end
               go_hunt();
            end
         end else begin
            phase = sfr_pkg::PH_HUNT;
            if (b == cfg.sync_byte) begin
               if (sync_seen != sfr_pkg::SYNC_MAX) begin
                  sync_seen = sync_seen + 4'd1;
               end
               if (int'(sync_seen) >= need) begin
                  phase = sfr_pkg::PH_HEADER;
                  position = '0;
                  frame_len = '0;
                  crc = '0;
                  crc_ok = 1'b0;
               end
            end else begin
               sync_seen = '0;
            end
         end
         expected_words.push_back(r);
      endfunction

      function void check_word(sfr_pkg::result_type got);
         sfr_pkg::result_type want;
         words_seen++;
         if (expected_words.size() == 0) begin
            $error("result word with nothing owed: data_byte %0h", got.data_byte);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         if (got.data_byte !== want.data_byte) begin
            $error("data_byte expected %0h got %0h", want.data_byte, got.data_byte);
            errors++;
         end
         if (got.in_frame !== want.in_frame) begin
            $error("in_frame expected %0d got %0d", want.in_frame, got.in_frame);
            errors++;
         end
         if (got.byte_index !== want.byte_index) begin
            $error("byte_index expected %0d got %0d", want.byte_index, got.byte_index);
            errors++;
         end
         if (got.frame_end !== want.frame_end) begin
            $error("frame_end expected %0d got %0d", want.frame_end, got.frame_end);
            errors++;
         end
         if (got.verdict !== want.verdict) begin
            $error("verdict expected %0d got %0d", want.verdict, got.verdict);
            errors++;
         end
         if (got.sender_address !== want.sender_address) begin
            $error("sender_address expected %0h got %0h", want.sender_address,
                   got.sender_address);
            errors++;
         end
         if (got.is_broadcast !== want.is_broadcast) begin
            $error("is_broadcast expected %0d got %0d", want.is_broadcast, got.is_broadcast);
            errors++;
         end
      endfunction
   endclass

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wdata;

   sfr_req_if req_ch();
   sfr_rsp_if rsp_ch();

   serial_frame_receiver_crc8 #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   rx_frame_tracker tracker = new();

   int bytes_sent = 0;
   int cycle_count = 0;
   int rsp_stall_left = 0;
   bit tx_gaps_on = 1'b1;
   bit rx_stalls_on = 1'b1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall_left <= pick_gap();
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         tracker.note_byte(req_ch.rx_byte);
      end
   end

   always @(posedge clock) begin : take_rsp
      sfr_pkg::result_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.data_byte = rsp_ch.data_byte;
         got.in_frame = rsp_ch.in_frame;
         got.byte_index = rsp_ch.byte_index;
         got.frame_end = rsp_ch.frame_end;
         got.verdict = sfr_pkg::verdict_type'(rsp_ch.verdict);
         got.sender_address = rsp_ch.sender_address;
         got.is_broadcast = rsp_ch.is_broadcast;
         tracker.check_word(got);
      end
   end

   task automatic send_byte(logic [7:0] b);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      bytes_sent++;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (tracker.words_seen < bytes_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(sfr_pkg::cfg_type c);
      logic [sfr_pkg::CSR_INDEX_W-1:0] idx [5];
      logic [sfr_pkg::CSR_DATA_W-1:0]  val [5];
      idx = '{sfr_pkg::CSR_OWN_ADDRESS, sfr_pkg::CSR_SYNC_BYTE, sfr_pkg::CSR_END_BYTE,
              sfr_pkg::CSR_MIN_LENGTH, sfr_pkg::CSR_SYNCS_NEEDED};
      val = '{16'(c.own_address), 16'(c.sync_byte), 16'(c.end_byte), c.min_length,
              16'(c.syncs_needed)};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         tracker.set_reg(idx[i], val[i]);
      end
      csr_we <= 1'b0;
   endtask

   // sync run, header, and for a legal length the body, crc and end byte;
   // cut drops that many bytes from the tail
   task automatic send_frame(int nsync, logic [7:0] dest, logic [7:0] src, logic [15:0] len,
                             logic [7:0] crc_flip, logic [7:0] end_val, int cut);
      logic [7:0] frame_q[$];
      logic [7:0] crc;
      int keep;
      frame_q = {dest, src, len[15:8], len[7:0]};
      if (len >= sfr_pkg::MIN_FRAME_LEN && len >= tracker.cfg.min_length &&
          int'(len) <= MAX_FRAME_BYTES) begin
         for (int i = 4; i < int'(len) - 2; i++) begin
            frame_q.push_back(8'($urandom));
         end
         crc = '0;
         foreach (frame_q[i]) begin
            crc = tracker.crc_next(crc, frame_q[i]);
         end
         frame_q.push_back(crc ^ crc_flip);
         frame_q.push_back(end_val);
      end
      keep = frame_q.size() - cut;
      repeat (nsync) send_byte(tracker.cfg.sync_byte);
      for (int i = 0; i < keep; i++) begin
         send_byte(frame_q[i]);
      end
   endtask

   task automatic send_random_frame(int len_req);
      int need;
      int nsync;
      int len;
      int lo;
      int r;
      int cut;
      logic [7:0] dest;
      logic [7:0] crc_flip;
      logic [7:0] end_val;
      need = (tracker.cfg.syncs_needed == 0) ? 1 : int'(tracker.cfg.syncs_needed);
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
      nsync = need;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         nsync = need + 1;
      end else if (r < 10) begin
         nsync = need - 1;
      end
      lo = (int'(tracker.cfg.min_length) > 6) ? int'(tracker.cfg.min_length) : 6;
      if (len_req > 0) begin
         len = len_req;
      end else if ($urandom_range(0, 99) < 8 || lo > MAX_FRAME_BYTES) begin
         case ($urandom_range(0, 3))
            0: len = $urandom_range(0, 5);
            1: len = $urandom_range(MAX_FRAME_BYTES + 1, 65535);
            2: len = 65535;
            default: len = lo - 1;
         endcase
      end else begin
         len = $urandom_range(lo, (lo + 14 < MAX_FRAME_BYTES) ? lo + 14 : MAX_FRAME_BYTES);
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
         dest = tracker.cfg.own_address;
      end else if (r < 70) begin
         dest = sfr_pkg::BROADCAST_ADDR;
      end else begin
         dest = 8'($urandom);
      end
      crc_flip = ($urandom_range(0, 99) < 12) ? 8'($urandom_range(1, 255)) : 8'h00;
      end_val = ($urandom_range(0, 99) < 10) ? 8'($urandom) : tracker.cfg.end_byte;
      cut = ($urandom_range(0, 99) < 4) ? $urandom_range(1, 5) : 0;
      send_frame(nsync, dest, 8'($urandom), 16'(len), crc_flip, end_val, cut);
   endtask

   task automatic run_phase(sfr_pkg::cfg_type c, int target, int long_len);
      int start;
      bit paused;
      wait_idle();
      apply_config(c);
      start = bytes_sent;
      paused = 1'b0;
      if (long_len > 0) begin
         send_random_frame(long_len);
      end
      while (bytes_sent - start < target) begin
         tx_gaps_on = ($urandom_range(0, 3) != 0);
         rx_stalls_on = ($urandom_range(0, 3) != 0);
         send_random_frame(0);
         if (!paused && bytes_sent - start > target / 2) begin
            // hold the sender until every owed word is back
            wait_idle();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      sfr_pkg::cfg_type c;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      c = '{8'h5a, 8'ha5, 8'h7e, 16'd6, 4'd2};
      apply_config(c);
      send_byte(8'h00);
      send_byte(8'hff);
      // length below the minimum, length one past the frame store, then a good broadcast
      send_frame(2, 8'h5a, 8'h00, 16'd5, 8'h00, 8'h7e, 0);
      send_frame(2, 8'h00, 8'hff, 16'(MAX_FRAME_BYTES + 1), 8'h00, 8'h7e, 0);
      send_frame(2, sfr_pkg::BROADCAST_ADDR, 8'h00, 16'd6, 8'h00, 8'h7e, 0);

      run_phase(c, 240, 0);
      // zero sync count acts as one
      run_phase('{8'h00, 8'h00, 8'h00, 16'h0000, 4'h0}, 180, 0);
      run_phase('{8'hff, 8'hff, 8'hff, 16'hffff, 4'hf}, 110, 0);
      c.own_address = 8'($urandom);
      c.sync_byte = 8'($urandom);
      c.end_byte = 8'($urandom);
      c.min_length = 16'($urandom_range(6, 12));
      c.syncs_needed = 4'($urandom_range(1, 8));
      run_phase(c, 440, MAX_FRAME_BYTES / 4);

      wait_idle();
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_channels.sv
hw/rtl/sfr_parser.sv
hw/rtl/serial_frame_receiver_crc8.sv
dv/tb.sv
